// ===== hdl/xild_pkg.sv =====
// Shared types and constants for the x86 instruction length decoder.
// Used by xild_lane, xild_merge and x86_instruction_length_decoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xild_pkg;

	// Input item: a code window, its valid byte count and its address.
	typedef struct packed {
		logic [63:0] window_low;
		logic [63:0] window_high;
		logic [4:0]  bytes_valid;
		logic [63:0] instr_address;
	} in_item_t;

	// Result item: length and decode fields of one instruction.
	typedef struct packed {
		logic [4:0]  length;
		logic        recognized;
		logic [10:0] prefix_flags;
		logic [7:0]  opcode_byte;
		logic        escape_0f;
		logic        wide_operand;
		logic        modrm_present;
		logic [7:0]  modrm_value;
		logic [3:0]  disp_bytes;
		logic [2:0]  imm_bytes;
		logic        has_target;
		logic [63:0] branch_target;
	} out_item_t;

	// What one lane finds when it treats its byte as a prefix or an opcode start.
	typedef struct packed {
		logic [10:0] prefix;
		logic        ok;
		logic        need_data_prefix;
		logic [4:0]  rel_len;
		logic [7:0]  opcode;
		logic        esc;
		logic        modrm_present;
		logic [7:0]  modrm;
		logic [3:0]  disp;
		logic [2:0]  imm;
		logic        has_target;
		logic [31:0] offset;
	} lane_res_t;

	// Merged decode of the whole window.
	typedef struct packed {
		logic        ok;
		logic [4:0]  length;
		logic [10:0] prefix;
		logic [7:0]  opcode;
		logic        esc;
		logic        wide;
		logic        modrm_present;
		logic [7:0]  modrm;
		logic [3:0]  disp;
		logic [2:0]  imm;
		logic        has_target;
		logic [31:0] offset;
	} merge_res_t;

	// Prefix bytes.
	localparam logic [7:0] BYTE_LOCK  = 8'hf0;
	localparam logic [7:0] BYTE_REPNZ = 8'hf2;
	localparam logic [7:0] BYTE_REPZ  = 8'hf3;
	localparam logic [7:0] BYTE_CS    = 8'h2e;
	localparam logic [7:0] BYTE_SS    = 8'h36;
	localparam logic [7:0] BYTE_DS    = 8'h3e;
	localparam logic [7:0] BYTE_ES    = 8'h26;
	localparam logic [7:0] BYTE_FS    = 8'h64;
	localparam logic [7:0] BYTE_GS    = 8'h65;
	localparam logic [7:0] BYTE_DATA  = 8'h66;
	localparam logic [7:0] BYTE_ADDR  = 8'h67;

	// Prefix flag bit positions.
	localparam int PFX_LOCK  = 0;
	localparam int PFX_REPNZ = 1;
	localparam int PFX_REPZ  = 2;
	localparam int PFX_CS    = 3;
	localparam int PFX_SS    = 4;
	localparam int PFX_DS    = 5;
	localparam int PFX_ES    = 6;
	localparam int PFX_FS    = 7;
	localparam int PFX_GS    = 8;
	localparam int PFX_DATA  = 9;
	localparam int PFX_ADDR  = 10;

	// Escape, VEX and REX bytes.
	localparam logic [7:0] BYTE_ESC_0F  = 8'h0f;
	localparam logic [7:0] BYTE_ESC_38  = 8'h38;
	localparam logic [7:0] BYTE_38_F6   = 8'hf6;
	localparam logic [7:0] BYTE_VEX2    = 8'hc5;
	localparam logic [7:0] BYTE_VEX3    = 8'hc4;
	localparam logic [7:0] BYTE_REX_LO  = 8'h40;
	localparam logic [7:0] BYTE_REX_HI  = 8'h4f;

endpackage

`default_nettype wire

// ===== hdl/xild_lane.sv =====
// One decode lane: classifies its byte as a prefix and decodes an opcode starting there.
// Depends on xild_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xild_lane (
	input  wire logic            long_mode,
	input  wire logic [5:0][7:0] code_bytes,
	output xild_pkg::lane_res_t  res
);

	logic [7:0] b0, b1, b2, b3, b4, b5;
	logic [7:0] mb, sb;
	logic [1:0] mod_f;
	logic [2:0] rm_f, reg_f;
	logic [3:0] m_disp;
	logic       m_sib;

	assign b0 = code_bytes[0];
	assign b1 = code_bytes[1];
	assign b2 = code_bytes[2];
	assign b3 = code_bytes[3];
	assign b4 = code_bytes[4];
	assign b5 = code_bytes[5];

	// Locate the ModRM and SIB bytes for each opcode map.
	always_comb begin
		if (b0 == xild_pkg::BYTE_ESC_0F) begin
			if (b1 == xild_pkg::BYTE_ESC_38) begin
				mb = b3;
				sb = b4;
			end else begin
				mb = b2;
				sb = b3;
			end
		end else begin
			mb = b1;
			sb = b2;
		end
	end

	assign mod_f = mb[7:6];
	assign rm_f  = mb[2:0];
	assign reg_f = mb[5:3];

	// SIB presence and displacement size from ModRM.
	always_comb begin
		m_sib  = 1'b0;
		m_disp = 4'd0;
		if (mod_f != 2'd3) begin
			if (rm_f == 3'd4) begin
				m_sib = 1'b1;
				if ((mod_f == 2'd0 && sb[2:0] == 3'd5) || mod_f == 2'd2) m_disp = 4'd4;
				else if (mod_f == 2'd1) m_disp = 4'd1;
			end else begin
				if (mod_f == 2'd0 && rm_f == 3'd5) m_disp = 4'd4;
				else if (mod_f == 2'd1) m_disp = 4'd1;
				else if (mod_f == 2'd2) m_disp = 4'd4;
			end
		end
	end

	// Opcode tables.
	always_comb begin
		logic [1:0]  oplen;
		logic        take_m;
		logic [2:0]  immv;
		logic [2:0]  rsz;
		logic [3:0]  moffs;
		logic        okv;
		logic        n66;
		logic        esc;
		logic [7:0]  opc;
		logic [3:0]  dsp;

		oplen  = 2'd1;
		take_m = 1'b0;
		immv   = 3'd0;
		rsz    = 3'd0;
		moffs  = 4'd0;
		okv    = 1'b0;
		n66    = 1'b0;
		esc    = 1'b0;
		opc    = b0;

		if (b0 == xild_pkg::BYTE_ESC_0F) begin
			esc   = 1'b1;
			opc   = b1;
			oplen = 2'd2;
			unique case (b1) inside
				[8'h80:8'h8f]: begin
					rsz = 3'd4;
					okv = 1'b1;
				end
				8'h1f, 8'ha5, 8'hb6, 8'hb7, 8'hbe, 8'hbf: begin
					take_m = 1'b1;
					okv    = 1'b1;
				end
				8'ha4: begin
					take_m = 1'b1;
					immv   = 3'd1;
					okv    = 1'b1;
				end
				8'ha0, 8'ha1, 8'ha8, 8'ha9: okv = 1'b1;
				xild_pkg::BYTE_ESC_38: begin
					oplen = 2'd3;
					if (b2 == xild_pkg::BYTE_38_F6) begin
						take_m = 1'b1;
						n66    = 1'b1;
						okv    = 1'b1;
					end
				end
				default: okv = 1'b0;
			endcase
		end else if (b0 < 8'h40) begin
			unique case (b0[2:0])
				3'd0, 3'd1, 3'd2, 3'd3: begin
					take_m = 1'b1;
					okv    = 1'b1;
				end
				3'd4: begin
					immv = 3'd1;
					okv  = 1'b1;
				end
				3'd5: begin
					immv = 3'd4;
					okv  = 1'b1;
				end
				default: okv = (b0 == 8'h06) || (b0 == 8'h07) || (b0 == 8'h0e) ||
					(b0 == 8'h16) || (b0 == 8'h17) || (b0 == 8'h1e) ||
					(b0 == 8'h1f) || (b0 == 8'h37) || (b0 == 8'h3f);
			endcase
		end else begin
			unique case (b0) inside
				[8'h40:8'h5f], 8'h90, 8'h98, 8'h99, 8'hc3, 8'hc9, 8'hcb: okv = 1'b1;
				[8'h70:8'h7f], 8'he3, 8'heb: begin
					rsz = 3'd1;
					okv = 1'b1;
				end
				[8'hb0:8'hb7], 8'h6a, 8'ha8, 8'hd4, 8'hd5: begin
					immv = 3'd1;
					okv  = 1'b1;
				end
				[8'hb8:8'hbf], 8'h68, 8'ha9: begin
					immv = 3'd4;
					okv  = 1'b1;
				end
				[8'ha0:8'ha3]: begin
					moffs = long_mode ? 4'd8 : 4'd4;
					okv   = 1'b1;
				end
				8'h80, 8'h83: begin
					take_m = 1'b1;
					immv   = 3'd1;
					okv    = 1'b1;
				end
				8'h81: begin
					take_m = 1'b1;
					immv   = 3'd4;
					okv    = 1'b1;
				end
				8'h84, 8'h85, [8'h88:8'h8e]: begin
					take_m = 1'b1;
					okv    = 1'b1;
				end
				8'h8f, 8'hc6, 8'hc7, 8'hf6, 8'hf7: begin
					take_m = 1'b1;
					okv    = (reg_f == 3'd0);
					if (b0 == 8'hc6 || b0 == 8'hf6) immv = 3'd1;
					else if (b0 == 8'hc7 || b0 == 8'hf7) immv = 3'd4;
				end
				8'h9a: begin
					immv = 3'd6;
					okv  = 1'b1;
				end
				8'hc0, 8'hc1: begin
					take_m = 1'b1;
					immv   = 3'd1;
					okv    = (reg_f != 3'd6);
				end
				[8'hd0:8'hd3]: begin
					take_m = 1'b1;
					okv    = (reg_f != 3'd6);
				end
				8'hc2, 8'hca: begin
					immv = 3'd2;
					okv  = 1'b1;
				end
				8'hc8: begin
					immv = 3'd3;
					okv  = 1'b1;
				end
				8'he8, 8'he9: begin
					rsz = 3'd4;
					okv = 1'b1;
				end
				8'hfe: begin
					take_m = 1'b1;
					okv    = (reg_f <= 3'd1);
				end
				8'hff: begin
					take_m = 1'b1;
					okv    = (reg_f <= 3'd2) || (reg_f == 3'd4) || (reg_f == 3'd6);
				end
				default: okv = 1'b0;
			endcase
		end

		dsp = take_m ? m_disp : moffs;

		res.ok               = okv;
		res.need_data_prefix = n66;
		res.rel_len          = 5'(oplen) + 5'(take_m) + 5'(take_m & m_sib) + 5'(dsp) +
			5'(immv) + 5'(rsz);
		res.opcode           = opc;
		res.esc              = esc;
		res.modrm_present    = take_m;
		res.modrm            = take_m ? mb : 8'h00;
		res.disp             = dsp;
		res.imm              = immv;
		res.has_target       = (rsz != 3'd0);
		if (rsz == 3'd1) res.offset = {{24{b1[7]}}, b1};
		else if (esc) res.offset = {b5, b4, b3, b2};
		else res.offset = {b4, b3, b2, b1};

		// Prefix classification of this lane's own byte.
		res.prefix = 11'd0;
		unique case (b0)
			xild_pkg::BYTE_LOCK:  res.prefix[xild_pkg::PFX_LOCK]  = 1'b1;
			xild_pkg::BYTE_REPNZ: res.prefix[xild_pkg::PFX_REPNZ] = 1'b1;
			xild_pkg::BYTE_REPZ:  res.prefix[xild_pkg::PFX_REPZ]  = 1'b1;
			xild_pkg::BYTE_CS:    res.prefix[xild_pkg::PFX_CS]    = 1'b1;
			xild_pkg::BYTE_SS:    res.prefix[xild_pkg::PFX_SS]    = 1'b1;
			xild_pkg::BYTE_DS:    res.prefix[xild_pkg::PFX_DS]    = 1'b1;
			xild_pkg::BYTE_ES:    res.prefix[xild_pkg::PFX_ES]    = 1'b1;
			xild_pkg::BYTE_FS:    res.prefix[xild_pkg::PFX_FS]    = 1'b1;
			xild_pkg::BYTE_GS:    res.prefix[xild_pkg::PFX_GS]    = 1'b1;
			xild_pkg::BYTE_DATA:  res.prefix[xild_pkg::PFX_DATA]  = 1'b1;
			xild_pkg::BYTE_ADDR:  res.prefix[xild_pkg::PFX_ADDR]  = 1'b1;
			default:              res.prefix = 11'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/xild_merge.sv =====
// Merge stage: prefix run, REX/VEX skip, opcode lane selection and length check.
// Depends on xild_pkg and the lane results of xild_lane.
`timescale 1ns / 1ps
`default_nettype none

module xild_merge #(
	parameter int WINDOW_BYTES = 16,
	localparam int CNT_W = $clog2(WINDOW_BYTES + 1)
) (
	input  wire logic                                   long_mode,
	input  wire xild_pkg::lane_res_t [WINDOW_BYTES-1:0] lanes,
	input  wire logic [WINDOW_BYTES-1:0][7:0]           code_bytes,
	input  wire logic [CNT_W-1:0]                       len,
	output xild_pkg::merge_res_t                        res,
	output logic [CNT_W-1:0]                            total_len
);

	localparam int IDX_W = $clog2(WINDOW_BYTES);
	localparam int POS_W = CNT_W + 3;

	always_comb begin
		logic                 run;
		logic [POS_W-1:0]     p;
		logic [POS_W-1:0]     q;
		logic [POS_W-1:0]     lenx;
		logic [POS_W-1:0]     total;
		logic [10:0]          flags;
		logic [7:0]           bp;
		logic [7:0]           rex;
		logic                 qok;
		xild_pkg::lane_res_t  sel;

		// Legacy prefixes run until the first lane that is not a prefix.
		run   = 1'b1;
		p     = POS_W'(WINDOW_BYTES);
		flags = 11'd0;
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			if (run) begin
				if (lanes[i].prefix == 11'd0) begin
					run = 1'b0;
					p   = POS_W'(i);
				end else begin
					flags = flags | lanes[i].prefix;
				end
			end
		end

		bp   = (p < POS_W'(WINDOW_BYTES)) ? code_bytes[p[IDX_W-1:0]] : 8'h00;
		lenx = POS_W'(len);

		// In long mode, skip a two- or three-byte VEX prefix or one REX byte.
		q   = p;
		rex = 8'h00;
		if (long_mode) begin
			if ((p + POS_W'(1) < lenx) && bp == xild_pkg::BYTE_VEX2) begin
				q = p + POS_W'(2);
			end else if ((p + POS_W'(2) < lenx) && bp == xild_pkg::BYTE_VEX3) begin
				q = p + POS_W'(3);
			end else if ((p < lenx) && bp >= xild_pkg::BYTE_REX_LO &&
				bp <= xild_pkg::BYTE_REX_HI) begin
				rex = bp;
				q   = p + POS_W'(1);
			end
		end

		// The lane at the opcode position holds the decode.
		qok   = (q < lenx);
		sel   = qok ? lanes[q[IDX_W-1:0]] : '0;
		total = q + POS_W'(sel.rel_len);

		res       = '0;
		total_len = '0;
		if (qok && sel.ok && (!sel.need_data_prefix || flags[xild_pkg::PFX_DATA]) &&
			total <= lenx) begin
			res.ok            = 1'b1;
			res.length        = total[4:0];
			res.prefix        = flags;
			res.opcode        = sel.opcode;
			res.esc           = sel.esc;
			res.wide          = rex[3];
			res.modrm_present = sel.modrm_present;
			res.modrm         = sel.modrm;
			res.disp          = sel.disp;
			res.imm           = sel.imm;
			res.has_target    = sel.has_target;
			res.offset        = sel.offset;
			total_len         = total[CNT_W-1:0];
		end else begin
			res.length = 5'd1;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/x86_instruction_length_decoder.sv =====
// Top level of the x86 instruction length decoder: lanes, merge and output pipeline.
// Depends on xild_pkg, xild_lane and xild_merge.
//
//  Port group     | Direction | Handshake          | Payload
//  in_*           | in        | in_valid/in_stall  | xild_pkg::in_item_t
//  out_*          | out       | out_valid/out_stall| xild_pkg::out_item_t
//  cfg_write_*    | in        | cfg_write_en       | long_mode bit
//
// One item enters per cycle unless a stall holds the output.
// Stage one runs one lane per window byte, stage two merges the lanes,
// stage three adds the 64-bit branch target into the output register.
// Reset clears the valid bits and long_mode. A stall on the output while it
// holds a valid item freezes all three stages and stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module x86_instruction_length_decoder #(
	parameter int WINDOW_BYTES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire xild_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output xild_pkg::out_item_t      out_data,
	input  wire logic                cfg_write_en,
	input  wire logic                cfg_write_data
);

	localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
	localparam int EXT_N = WINDOW_BYTES + 5;

	logic                                   long_mode_q;
	logic                                   adv;
	logic [127:0]                           win;
	logic [5:0]                             bv_ext;
	logic [CNT_W-1:0]                       len_c;
	logic [EXT_N-1:0][7:0]                  ext;
	xild_pkg::lane_res_t [WINDOW_BYTES-1:0] lanes_c;

	logic                                   valid_s1;
	xild_pkg::lane_res_t [WINDOW_BYTES-1:0] lanes_s1;
	logic [WINDOW_BYTES-1:0][7:0]           bytes_s1;
	logic [CNT_W-1:0]                       len_s1;
	logic [63:0]                            addr_s1;

	xild_pkg::merge_res_t                   merge_c;
	logic [CNT_W-1:0]                       total_c;

	logic                                   valid_s2;
	xild_pkg::merge_res_t                   merge_s2;
	logic [CNT_W-1:0]                       total_s2;
	logic [63:0]                            addr_s2;

	logic                                   out_valid_q;
	xild_pkg::out_item_t                    out_data_q;

	// The whole pipeline moves unless a finished item is held at the output.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			long_mode_q <= cfg_write_data;
		end
	end

	// Clamp the byte count to the window and zero the bytes past it.
	assign win    = {in_data.window_high, in_data.window_low};
	assign bv_ext = {1'b0, in_data.bytes_valid};
	always_comb begin
		if (bv_ext > 6'(WINDOW_BYTES)) len_c = CNT_W'(WINDOW_BYTES);
		else len_c = CNT_W'(bv_ext);
	end

	for (genvar i = 0; i < EXT_N; i++) begin : g_byte
		if (i < 16 && i < WINDOW_BYTES) begin : g_real
			assign ext[i] = (CNT_W'(i) < len_c) ? win[i*8 +: 8] : 8'h00;
		end else begin : g_zero
			assign ext[i] = 8'h00;
		end
	end

	// One lane for each window byte.
	for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_lane
		xild_lane u_lane (
			.long_mode  (long_mode_q),
			.code_bytes (ext[i+5:i]),
			.res        (lanes_c[i])
		);
	end

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lanes_s1 <= lanes_c;
			bytes_s1 <= ext[WINDOW_BYTES-1:0];
			len_s1   <= len_c;
			addr_s1  <= in_data.instr_address;
		end
	end

	xild_merge #(
		.WINDOW_BYTES (WINDOW_BYTES)
	) u_merge (
		.long_mode  (long_mode_q),
		.lanes      (lanes_s1),
		.code_bytes (bytes_s1),
		.len        (len_s1),
		.res        (merge_c),
		.total_len  (total_c)
	);

	// Stage two registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			merge_s2 <= merge_c;
			total_s2 <= total_c;
			addr_s2  <= addr_s1;
		end
	end

	// Output register with the branch target sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.length        <= merge_s2.length;
			out_data_q.recognized    <= merge_s2.ok;
			out_data_q.prefix_flags  <= merge_s2.prefix;
			out_data_q.opcode_byte   <= merge_s2.opcode;
			out_data_q.escape_0f     <= merge_s2.esc;
			out_data_q.wide_operand  <= merge_s2.wide;
			out_data_q.modrm_present <= merge_s2.modrm_present;
			out_data_q.modrm_value   <= merge_s2.modrm;
			out_data_q.disp_bytes    <= merge_s2.disp;
			out_data_q.imm_bytes     <= merge_s2.imm;
			out_data_q.has_target    <= merge_s2.has_target;
			out_data_q.branch_target <= merge_s2.has_target ?
				(addr_s2 + 64'(total_s2) + {{32{merge_s2.offset[31]}}, merge_s2.offset}) :
				64'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
